// ===== sv/base64_codec_defines.svh =====
// Assertion macros used by the base64_codec checker.
// No dependencies; include by bare file name.
`ifndef BASE64_CODEC_DEFINES_SVH
`define BASE64_CODEC_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define B64C_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("base64_codec check failed");

// Next-cycle implication, disabled during reset.
`define B64C_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("base64_codec check failed");

`endif

// ===== sv/b64c_pkg.sv =====
// Shared types, constants and character mapping functions for base64_codec.
// No dependencies.
package b64c_pkg;

   localparam int B64C_QUEUE_DEPTH = 4;

   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_SLASH   = 8'h2F;
   localparam logic [7:0] CHAR_PAD     = 8'h3D;

   localparam logic [6:0] IDX_PAD      = 7'h40;
   localparam logic [7:0] VAL_PAD      = 8'h40;
   localparam logic [7:0] VAL_INVALID  = 8'hFF;

   // One queued work unit: up to four data bytes plus framing flags.
   typedef struct packed {
      logic [3:0][7:0] data;   // data[0] goes out first
      logic [2:0]      cnt;    // number of valid data bytes, 0..4
      logic            bad;    // error result leads the unit
      logic            last;   // unit ends the message
   } job_type;

   // 6-bit value (or pad index) to alphabet character.
   function automatic logic [7:0] enc_char(input logic [6:0] idx);
      logic [7:0] r;
      if (idx < 7'd26) begin
         r = CHAR_UPPER_A + 8'(idx);
      end else if (idx < 7'd52) begin
         r = CHAR_LOWER_A + 8'(idx) - 8'd26;
      end else if (idx < 7'd62) begin
         r = CHAR_ZERO + 8'(idx) - 8'd52;
      end else if (idx == 7'd62) begin
         r = CHAR_PLUS;
      end else if (idx == 7'd63) begin
         r = CHAR_SLASH;
      end else begin
         r = CHAR_PAD;
      end
      return r;
   endfunction

   // Character to 6-bit value; VAL_PAD for '=', VAL_INVALID otherwise.
   function automatic logic [7:0] char_value(input logic [7:0] c);
      logic [7:0] r;
      if (c inside {[8'h41:8'h5A]}) begin
         r = c - CHAR_UPPER_A;
      end else if (c inside {[8'h61:8'h7A]}) begin
         r = c - CHAR_LOWER_A + 8'd26;
      end else if (c inside {[8'h30:8'h39]}) begin
         r = c - CHAR_ZERO + 8'd52;
      end else if (c == CHAR_PLUS) begin
         r = 8'd62;
      end else if (c == CHAR_SLASH) begin
         r = 8'd63;
      end else if (c == CHAR_PAD) begin
         r = VAL_PAD;
      end else begin
         r = VAL_INVALID;
      end
      return r;
   endfunction

endpackage

// ===== sv/base64_codec.sv =====
// Streaming Base64 codec (standard alphabet, '=' padding), top level.
// Encode mode takes raw bytes and returns characters; in encode mode every
// third byte, or a byte with req_tlast, produces four characters with '='
// filling a short final group. Decode mode takes characters and returns
// bytes: four values produce three bytes, a final group of k values produces
// k-1 bytes, '=' is skipped, and any other non-alphabet character produces
// one error result (rsp_tuser[1]) and is dropped. A message end that yields
// nothing gives one marker result with no data and rsp_tlast set. Writing
// decode_mode on the csr port clears the partial group; write it only while
// the block is idle. An item is accepted each cycle while the job queue has
// room; its job passes through the queue and then the output register. The
// output serializer moves one result per cycle while rsp_tready allows, so
// the rate is set by results per item: decode runs at one character per
// cycle, while encode yields four results per three bytes in long messages,
// two per byte when messages are two bytes long, and four per byte if every
// byte ends a message. The queue absorbs bursts of up to QUEUE_DEPTH jobs.
// Depends on b64c_pkg.
module base64_codec #(
   parameter int QUEUE_DEPTH = b64c_pkg::B64C_QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   // configuration: decode_mode
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_data,
   // input items
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,    // [7:0] in_byte
   input  logic       req_tlast,    // end_of_message
   // results
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,    // [7:0] out_byte
   output logic       rsp_tlast,    // last
   output logic [1:0] rsp_tuser     // [0] has_data, [1] bad_char
);
   import b64c_pkg::*;

   logic    accept;
   logic    push, full, pop, head_valid;
   job_type push_job, head_job;

   // register writes are always taken and land in the next cycle
   assign csr_ready  = 1'b1;
   assign req_tready = !full;
   assign accept     = req_tvalid && !full;

   b64c_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .accept    (accept),
      .in_byte   (req_tdata),
      .in_last   (req_tlast),
      .push      (push),
      .job       (push_job)
   );

   b64c_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   b64c_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== sv/b64c_front.sv =====
// Front end of base64_codec: accepts items, holds the group state and mode,
// and turns each item into a job for the queue. Depends on b64c_pkg.
module b64c_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   input  logic              csr_data,
   input  logic              accept,
   input  logic [7:0]        in_byte,
   input  logic              in_last,
   output logic              push,
   output b64c_pkg::job_type job
);
   import b64c_pkg::*;

   logic        mode_ff, mode_in;
   logic [23:0] gbits_ff, gbits_in;
   logic [1:0]  gcnt_ff, gcnt_in;

   logic [23:0] enc_shift, enc_align;
   logic [2:0]  enc_k, enc_used;
   logic        enc_done;

   logic [7:0]  dec_val;
   logic        dec_bad, dec_take;
   logic [23:0] dec_g1, dec_g2, dec_align;
   logic [2:0]  dec_k1, dec_k2;

   logic [3:0][7:0] d;
   logic [2:0]      m;
   logic [6:0]      cidx;

   always_comb begin
      // encode path
      enc_shift = {gbits_ff[15:0], in_byte};
      enc_k     = {1'b0, gcnt_ff} + 3'd1;
      enc_done  = (enc_k >= 3'd3) || in_last;
      enc_used  = (enc_k >= 3'd3) ? 3'd3 : enc_k;
      case (enc_used)
         3'd1:    enc_align = {enc_shift[7:0], 16'h0000};
         3'd2:    enc_align = {enc_shift[15:0], 8'h00};
         default: enc_align = enc_shift;
      endcase

      // decode path
      dec_val  = char_value(in_byte);
      dec_bad  = (dec_val == VAL_INVALID);
      dec_take = !dec_bad && (dec_val != VAL_PAD);
      dec_g1   = dec_take ? {gbits_ff[17:0], dec_val[5:0]} : gbits_ff;
      dec_k1   = {1'b0, gcnt_ff} + {2'b00, dec_take};
      dec_g2   = (dec_k1 == 3'd4) ? 24'h000000 : dec_g1;
      dec_k2   = (dec_k1 == 3'd4) ? 3'd0 : dec_k1;
      case (dec_k2)
         3'd1:    dec_align = {dec_g2[5:0], 18'h00000};
         3'd2:    dec_align = {dec_g2[11:0], 12'h000};
         default: dec_align = {dec_g2[17:0], 6'h00};
      endcase

      d        = '0;
      m        = 3'd0;
      cidx     = '0;
      gbits_in = gbits_ff;
      gcnt_in  = gcnt_ff;
      if (!mode_ff) begin
         for (int i = 0; i < 4; i++) begin
            cidx = (3'(i) > enc_used) ? IDX_PAD : {1'b0, enc_align[23 - 6 * i -: 6]};
            d[i] = enc_char(cidx);
         end
         m        = enc_done ? 3'd4 : 3'd0;
         gbits_in = enc_done ? 24'h000000 : enc_shift;
         gcnt_in  = enc_done ? 2'd0 : enc_k[1:0];
      end else begin
         if (dec_k1 == 3'd4) begin
            d[0] = dec_g1[23:16];
            d[1] = dec_g1[15:8];
            d[2] = dec_g1[7:0];
            m    = 3'd3;
         end else if (in_last && (dec_k2 != 3'd0)) begin
            d[0] = dec_align[23:16];
            d[1] = dec_align[15:8];
            d[2] = dec_align[7:0];
            m    = dec_k2 - 3'd1;
         end
         gbits_in = dec_g2;
         gcnt_in  = dec_k2[1:0];
      end
      if (in_last) begin
         gbits_in = 24'h000000;
         gcnt_in  = 2'd0;
      end

      job.data = d;
      job.cnt  = m;
      job.bad  = mode_ff && dec_bad;
      job.last = in_last;
      push     = accept && ((m != 3'd0) || job.bad || in_last);

      mode_in = csr_valid ? csr_data : mode_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= 1'b0;
         gbits_ff <= '0;
         gcnt_ff  <= '0;
      end else begin
         mode_ff <= mode_in;
         if (csr_valid) begin
            gbits_ff <= '0;
            gcnt_ff  <= '0;
         end else if (accept) begin
            gbits_ff <= gbits_in;
            gcnt_ff  <= gcnt_in;
         end
      end
   end

endmodule

// ===== sv/b64c_queue.sv =====
// Short job queue between the front and back ends of base64_codec.
// Depends on b64c_pkg.
module b64c_queue #(
   parameter int DEPTH = b64c_pkg::B64C_QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  b64c_pkg::job_type push_job,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output b64c_pkg::job_type head_job
);
   import b64c_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   job_type         slots_ff [DEPTH];
   logic [AW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]   cnt_ff, cnt_in;

   always_comb begin
      full       = (cnt_ff == CW'(DEPTH));
      head_valid = (cnt_ff != '0);
      head_job   = slots_ff[rd_ff];
      wr_in      = (wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + AW'(1);
      rd_in      = (rd_ff == AW'(DEPTH - 1)) ? '0 : rd_ff + AW'(1);
      cnt_in     = cnt_ff + CW'(push) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= wr_in;
         end
         if (pop) begin
            rd_ff <= rd_in;
         end
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ===== sv/b64c_back.sv =====
// Back end of base64_codec: serializes queued jobs into single results
// through an output register. Depends on b64c_pkg.
module b64c_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  b64c_pkg::job_type head_job,
   output logic              pop,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [7:0]        rsp_tdata,
   output logic              rsp_tlast,
   output logic [1:0]        rsp_tuser
);
   import b64c_pkg::*;

   logic [1:0] idx_ff, idx_in;
   logic       vld_ff, vld_in;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff, last_in;
   logic       has_ff, has_in;
   logic       bad_ff, bad_in;

   logic [2:0] total;
   logic       load, final_slot;
   logic [1:0] didx;

   always_comb begin
      total      = head_job.cnt + {2'b00, head_job.bad};
      if (total == 3'd0) begin
         total = 3'd1;
      end
      final_slot = ({1'b0, idx_ff} == total - 3'd1);
      load       = head_valid && (!vld_ff || rsp_tready);
      pop        = load && final_slot;
      didx       = idx_ff - {1'b0, head_job.bad};

      if (head_job.bad && (idx_ff == 2'd0)) begin
         byte_in = 8'h00;
         has_in  = 1'b0;
         bad_in  = 1'b1;
      end else if (head_job.cnt == 3'd0) begin
         byte_in = 8'h00;
         has_in  = 1'b0;
         bad_in  = 1'b0;
      end else begin
         byte_in = head_job.data[didx];
         has_in  = 1'b1;
         bad_in  = 1'b0;
      end
      last_in = head_job.last && final_slot;

      // hold the slot index until the job drains
      idx_in = idx_ff;
      if (load) begin
         idx_in = final_slot ? 2'd0 : idx_ff + 2'd1;
      end

      vld_in = vld_ff;
      if (load) begin
         vld_in = 1'b1;
      end else if (rsp_tready) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         vld_ff <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= byte_in;
         last_ff <= last_in;
         has_ff  <= has_in;
         bad_ff  <= bad_in;
      end
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_tdata  = byte_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = {bad_ff, has_ff};

endmodule

// ===== sv/b64c_checker.sv =====
// Port-level checks for base64_codec, attached by bind.
// Depends on base64_codec_defines.svh.
`include "base64_codec_defines.svh"

module b64c_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast,
   input logic [1:0] rsp_tuser
);

   // a stalled result keeps its contents
   `B64C_ASSERT_NEXT(rsp_hold_chk, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser))

   // an error result never carries data
   `B64C_ASSERT_IMPLIES(bad_no_data_chk, clock, reset, rsp_tvalid && rsp_tuser[1], !rsp_tuser[0] && (rsp_tdata == 8'h00))

   // a result with neither data nor error is only the end marker
   `B64C_ASSERT_IMPLIES(marker_last_chk, clock, reset, rsp_tvalid && !rsp_tuser[0] && !rsp_tuser[1], rsp_tlast && (rsp_tdata == 8'h00))

endmodule

bind base64_codec b64c_checker u_b64c_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);
